@@ design/sha256_stream_hasher_defines.svh @@
// assertion macros for the sha-256 stream hasher checker
// used by the checker file only
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define SHA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication checked outside reset
`define SHA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

@@ design/sha_pkg.sv @@
// shared types, constants and functions of the sha-256 stream hasher
// no dependencies
package sha_pkg;
   localparam int QueueDepth = 4;
   localparam logic OpAbsorb = 1'b0;
   localparam logic OpFinish = 1'b1;

   typedef struct packed {
      logic       op;
      logic [7:0] data_byte;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PAD, ST_LEN, ST_COMP, ST_EMIT
   } back_state_type;

   localparam logic [31:0] RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
      32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
      32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
      32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
      32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
      32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
      32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
      32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
      32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] InitH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction
endpackage

@@ design/sha_ifc.sv @@
// valid/ready channel interfaces for request and response items
// depends on nothing
interface sha_req_ifc;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] data_byte;
   modport source (output valid, op, data_byte, input ready);
   modport sink (input valid, op, data_byte, output ready);
endinterface

interface sha_rsp_ifc;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;
   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ design/sha_ram.sv @@
// generic simple dual-port ram (one write port, one read port) with registered read
// no dependencies
module sha_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

@@ design/sha_front.sv @@
// front end: accepts request items into a short queue
// depends on sha_pkg and sha_ifc
module sha_front #(
   parameter int Depth = 4
) (
   input  logic clock,
   input  logic reset,
   sha_req_ifc.sink req,
   output sha_pkg::item_type q_item,
   output logic q_valid,
   input  logic q_pop
);
   import sha_pkg::*;
   localparam int AW = $clog2(Depth);

   item_type       mem_ff [Depth];
   logic [AW-1:0]  wr_ff, rd_ff;
   logic [AW:0]    cnt_ff;
   logic           push;
   logic           pop;

   assign req.ready = (cnt_ff != (AW+1)'(Depth));
   assign push = req.valid && req.ready;
   assign q_valid = (cnt_ff != '0);
   assign pop = q_pop && q_valid;
   assign q_item = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == AW'(Depth - 1)) ? '0 : wr_ff + 1'b1;
         if (pop) rd_ff <= (rd_ff == AW'(Depth - 1)) ? '0 : rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
      if (push) mem_ff[wr_ff] <= '{op: req.op, data_byte: req.data_byte};
   end
endmodule

@@ design/sha_back.sv @@
// back end: block buffer, padding sequencer, round engine, digest output
// depends on sha_pkg, sha_ifc and sha_ram
module sha_back (
   input  logic clock,
   input  logic reset,
   input  sha_pkg::item_type q_item,
   input  logic q_valid,
   output logic q_pop,
   sha_rsp_ifc.source rsp
);
   import sha_pkg::*;

   // round engine schedule: setup, byte loads, rounds, final add
   localparam logic [7:0] LoadLast   = 8'd64;
   localparam logic [7:0] RoundFirst = 8'd65;
   localparam logic [7:0] RoundLast  = 8'd128;
   localparam logic [7:0] AddCycle   = 8'd129;
   localparam logic [5:0] LenPos     = 6'd56;
   localparam logic [5:0] BlockEnd   = 6'd63;
   localparam logic [7:0] PadByte    = 8'h80;

   back_state_type state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;
   logic [60:0] len_ff, len_in;
   logic        spill_ff, spill_in;
   logic        last_blk_ff, last_blk_in;
   logic [7:0]  cnt_ff, cnt_in;
   logic [2:0]  emit_ff, emit_in;
   logic [31:0] h_ff [8];
   logic [31:0] v_ff [8];
   logic [31:0] w_ff [16];

   logic        wr_en;
   logic [5:0]  wr_addr;
   logic [7:0]  wr_data;
   logic [5:0]  rd_addr;
   logic [7:0]  rd_data;
   logic [63:0] bits;
   logic [2:0]  len_sel;
   logic [31:0] t1, t2, s0, s1, wn;
   logic [5:0]  rt;

   sha_ram #(.Width(8), .Depth(64)) u_buf (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign bits = {len_ff, 3'b000};
   assign rd_addr = cnt_ff[5:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               if (q_item.op == OpFinish) state_in = ST_PAD;
               else if (fill_ff == BlockEnd) state_in = ST_COMP;
            end
         end
         ST_PAD: begin
            // a spilled pad fills to the block end first, else stops at the length
            if (spill_ff) begin
               if (fill_ff == 6'd0) state_in = ST_COMP;
            end else if (fill_ff == LenPos) begin
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            if (fill_ff == BlockEnd) state_in = ST_COMP;
         end
         ST_COMP: begin
            if (cnt_ff == AddCycle) begin
               if (last_blk_ff) state_in = ST_EMIT;
               else if (spill_ff) state_in = ST_PAD;
               else state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (rsp.ready && emit_ff == 3'd7) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      q_pop = 1'b0;
      wr_en = 1'b0;
      wr_addr = fill_ff;
      wr_data = 8'h00;
      len_sel = ~fill_ff[2:0];
      fill_in = fill_ff;
      len_in = len_ff;
      spill_in = spill_ff;
      last_blk_in = last_blk_ff;
      cnt_in = 8'd0;
      emit_in = emit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            q_pop = q_valid;
            if (q_valid) begin
               wr_en = 1'b1;
               fill_in = fill_ff + 6'd1;
               if (q_item.op == OpFinish) begin
                  wr_data = PadByte;
                  spill_in = (fill_ff >= LenPos);
               end else begin
                  wr_data = q_item.data_byte;
                  len_in = len_ff + 61'd1;
               end
            end
         end
         ST_PAD: begin
            if (spill_ff ? (fill_ff != 6'd0) : (fill_ff != LenPos)) begin
               wr_en = 1'b1;
               fill_in = fill_ff + 6'd1;
            end
         end
         ST_LEN: begin
            // bit length, most significant byte first
            wr_en = 1'b1;
            wr_data = bits[{len_sel, 3'b000} +: 8];
            fill_in = fill_ff + 6'd1;
            if (fill_ff == BlockEnd) last_blk_in = 1'b1;
         end
         ST_COMP: begin
            if (cnt_ff != AddCycle) cnt_in = cnt_ff + 8'd1;
            else spill_in = 1'b0;
         end
         ST_EMIT: begin
            if (rsp.ready) begin
               emit_in = emit_ff + 3'd1;
               if (emit_ff == 3'd7) begin
                  len_in = '0;
                  last_blk_in = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   // round engine: one setup step, 64 byte loads (ram read is registered), 64 rounds
   always_comb begin
      rt = 6'(cnt_ff - RoundFirst);
      s0 = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wn = w_ff[0] + s0 + w_ff[9] + s1;
      t1 = v_ff[7] + (rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25))
         + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) + RoundK[rt] + w_ff[0];
      t2 = (rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22))
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_COMP) begin
         if (cnt_ff == 8'd0) begin
            for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
         end
         if (cnt_ff >= 8'd1 && cnt_ff <= LoadLast) begin
            // whole window moves one byte, byte 0 ends at the top of word 0
            for (int i = 0; i < 15; i++) w_ff[i] <= {w_ff[i][23:0], w_ff[i+1][31:24]};
            w_ff[15] <= {w_ff[15][23:0], rd_data};
         end else if (cnt_ff >= RoundFirst && cnt_ff <= RoundLast) begin
            for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
            w_ff[15] <= wn;
            v_ff[7] <= v_ff[6]; v_ff[6] <= v_ff[5]; v_ff[5] <= v_ff[4];
            v_ff[4] <= v_ff[3] + t1;
            v_ff[3] <= v_ff[2]; v_ff[2] <= v_ff[1]; v_ff[1] <= v_ff[0];
            v_ff[0] <= t1 + t2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff <= '0;
         len_ff <= '0;
         spill_ff <= 1'b0;
         last_blk_ff <= 1'b0;
         cnt_ff <= '0;
         emit_ff <= '0;
         for (int i = 0; i < 8; i++) h_ff[i] <= InitH[i];
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         len_ff <= len_in;
         spill_ff <= spill_in;
         last_blk_ff <= last_blk_in;
         cnt_ff <= cnt_in;
         emit_ff <= emit_in;
         if (state_ff == ST_COMP && cnt_ff == AddCycle) begin
            for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
         end else if (state_ff == ST_EMIT && rsp.ready && emit_ff == 3'd7) begin
            for (int i = 0; i < 8; i++) h_ff[i] <= InitH[i];
         end
      end
   end

   assign rsp.valid = (state_ff == ST_EMIT);
   assign rsp.digest_word = h_ff[emit_ff];
   assign rsp.word_index = emit_ff;
   assign rsp.last_word = (emit_ff == 3'd7);
endmodule

@@ design/sha256_stream_hasher.sv @@
// top level of the sha-256 stream hasher
// depends on sha_pkg, sha_ifc, sha_front, sha_back
//
//  channel | dir | fields
//  req     | in  | op, data_byte
//  rsp     | out | digest_word, word_index, last_word
//
// items enter the queue one a cycle while it has room; the back end takes one a cycle while idle
// the 64th byte of a block starts a compression (one setup, 64 byte
// loads, 64 rounds, one final add), during which the back end takes no items
// finish writes the pad byte, zero fill and eight length bytes, runs one or two
// compressions, then holds each of the eight digest items while rsp.ready is low
// synchronous active-high reset restores the initial hash values
module sha256_stream_hasher #(
   parameter int QDepth = sha_pkg::QueueDepth
) (
   input logic clock,
   input logic reset,
   sha_req_ifc.sink req,
   sha_rsp_ifc.source rsp
);
   import sha_pkg::*;

   item_type q_item;
   logic     q_valid;
   logic     q_pop;

   // queue between acceptance and execution
   sha_front #(.Depth(QDepth)) u_front (
      .clock(clock), .reset(reset), .req(req),
      .q_item(q_item), .q_valid(q_valid), .q_pop(q_pop)
   );

   // buffer, padding and compression
   sha_back u_back (
      .clock(clock), .reset(reset), .q_item(q_item), .q_valid(q_valid),
      .q_pop(q_pop), .rsp(rsp)
   );
endmodule

@@ design/sha256_stream_hasher_checker.sv @@
// port-level checker for the sha-256 stream hasher, with its bind
// depends on sha256_stream_hasher_defines.svh
`include "sha256_stream_hasher_defines.svh"
module sha256_stream_hasher_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_word_index,
   input logic       rsp_last_word
);
   `SHA_ASSERT_IMP(a_last, clock, reset, rsp_valid, rsp_last_word == (rsp_word_index == 3'd7), "last flag wrong")
   `SHA_ASSERT_NXT(a_seq, clock, reset, rsp_valid && rsp_ready && !rsp_last_word, rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1, "word order broken")
   `SHA_ASSERT_NXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word_index), "stalled item changed")
endmodule

bind sha256_stream_hasher sha256_stream_hasher_checker u_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_word_index(rsp.word_index), .rsp_last_word(rsp.last_word)
);
